// ===== rtl/lir_pkg.sv =====
// Package for the linear interpolation audio resampler.
// Holds the fixed-point widths, register indexes and a phase helper.
// No dependencies; every other file in rtl/ uses it.
package lir_pkg;

    localparam int SAMPLE_W     = 16;
    localparam int FRAC_BITS    = 16;
    localparam int MAX_UPSAMPLE = 16;
    localparam int RATIO_W      = 21;
    localparam int PHASE_W      = 21;
    localparam int WORK_W       = PHASE_W + 1;
    localparam int CNT_W        = $clog2(MAX_UPSAMPLE);
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = RATIO_W;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic [PHASE_W-1:0]         t_phase;
    typedef logic [WORK_W-1:0]          t_work;
    typedef logic [RATIO_W-1:0]         t_ratio;
    typedef logic [FRAC_BITS-1:0]       t_frac;
    typedef logic [CNT_W-1:0]           t_cnt;
    typedef logic [CFG_IDX_W-1:0]       t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0]      t_cfg_data;

    localparam t_cfg_idx CFG_RATIO = 1'd0;
    localparam t_cfg_idx CFG_MONO  = 1'd1;

    localparam t_sample SAMPLE_MAX = 16'sh7FFF;
    localparam t_sample SAMPLE_MIN = 16'sh8000;

    localparam t_ratio RATIO_RESET = t_ratio'(65536);
    localparam t_work  ONE_FRAME   = t_work'(1) << FRAC_BITS;
    localparam t_work  PHASE_MAX   = t_work'({PHASE_W{1'b1}});

    // Takes one frame off the working phase, or zero when the run was cut
    // short, and saturates to the stored phase width.
    function automatic t_phase phase_wrap(input t_work x);
        t_work y;
        y = (x >= ONE_FRAME) ? (x - ONE_FRAME) : '0;
        if (y > PHASE_MAX) begin
            y = PHASE_MAX;
        end
        return y[PHASE_W-1:0];
    endfunction

endpackage

// ===== rtl/lir_if.sv =====
// Valid/ready channel interfaces of the linear interpolation resampler.
// Input frames, output frames and configuration writes.
// Depends on lir_pkg.
interface lir_in_if;
    logic              valid;
    logic              ready;
    lir_pkg::t_sample  left_sample;
    lir_pkg::t_sample  right_sample;
    logic              restart;

    modport source(output valid, left_sample, right_sample, restart, input ready);
    modport sink(input valid, left_sample, right_sample, restart, output ready);
endinterface

interface lir_out_if;
    logic              valid;
    logic              ready;
    lir_pkg::t_sample  out_left;
    lir_pkg::t_sample  out_right;
    logic              last_of_run;

    modport source(output valid, out_left, out_right, last_of_run, input ready);
    modport sink(input valid, out_left, out_right, last_of_run, output ready);
endinterface

interface lir_cfg_if;
    logic                valid;
    logic                ready;
    lir_pkg::t_cfg_idx   wr_index;
    lir_pkg::t_cfg_data  wr_data;

    modport source(output valid, wr_index, wr_data, input ready);
    modport sink(input valid, wr_index, wr_data, output ready);
endinterface

// ===== rtl/lir_interp.sv =====
// Shared interpolation unit: a + f*(b-a) over 2^FRAC_BITS, truncated
// toward zero and clamped. Product registered; result combinational from it.
// Depends on lir_pkg.
module lir_interp (
    input  logic              i_clk,
    input  lir_pkg::t_sample  i_a,
    input  lir_pkg::t_sample  i_b,
    input  lir_pkg::t_frac    i_frac,
    output lir_pkg::t_sample  o_q
);

    localparam int DIFF_W = lir_pkg::SAMPLE_W + 1;
    localparam int PROD_W = lir_pkg::FRAC_BITS + 1 + DIFF_W;
    localparam int NUM_W  = PROD_W + 1;
    localparam int Q_W    = NUM_W - lir_pkg::FRAC_BITS;

    logic signed [DIFF_W-1:0] w_diff;
    logic signed [PROD_W-1:0] n_prod;
    logic signed [PROD_W-1:0] r_prod;
    lir_pkg::t_sample         r_a;
    logic signed [NUM_W-1:0]  w_num;
    logic signed [NUM_W-1:0]  w_adj;
    logic signed [Q_W-1:0]    w_q;

    assign w_diff = {i_b[lir_pkg::SAMPLE_W-1], i_b} - {i_a[lir_pkg::SAMPLE_W-1], i_a};
    assign n_prod = $signed({1'b0, i_frac}) * w_diff;

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        r_a    <= i_a;
    end

    assign w_num = {{(NUM_W-lir_pkg::SAMPLE_W-lir_pkg::FRAC_BITS){r_a[lir_pkg::SAMPLE_W-1]}},
                    r_a, {lir_pkg::FRAC_BITS{1'b0}}}
                 + {{(NUM_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};

    // Negative values are biased so the arithmetic shift rounds toward zero.
    assign w_adj = w_num[NUM_W-1]
                 ? (w_num + NUM_W'((64'd1 << lir_pkg::FRAC_BITS) - 64'd1))
                 : w_num;
    assign w_q   = w_adj[NUM_W-1:lir_pkg::FRAC_BITS];

    always_comb begin
        if (w_q > Q_W'(lir_pkg::SAMPLE_MAX)) begin
            o_q = lir_pkg::SAMPLE_MAX;
        end else if (w_q < Q_W'(lir_pkg::SAMPLE_MIN)) begin
            o_q = lir_pkg::SAMPLE_MIN;
        end else begin
            o_q = w_q[lir_pkg::SAMPLE_W-1:0];
        end
    end

endmodule

// ===== rtl/linear_interp_audio_resampler.sv =====
// Top level of the linear interpolation audio resampler: sequencer, state,
// configuration registers and output register around the shared unit.
// Depends on lir_pkg, lir_if.sv and lir_interp.
//
// Channel  | Direction | Payload
// i_in     | in        | left_sample, right_sample, restart
// o_out    | out       | out_left, out_right, last_of_run
// i_cfg    | in        | wr_index (0 ratio, 1 mono), wr_data
//
// Each output frame steps the shared multiplier through S_MUL_L (left product),
// S_MUL_R (right product) and S_EMIT (transfer into the output register).
// An input item gives up to 16 output frames.
// Input is not ready while a run is in progress; a full output register stalls it.
// Synchronous active-low reset clears history, phase and mono, and sets ratio 1.0.
module linear_interp_audio_resampler (
    input logic        i_clk,
    input logic        i_rst_n,
    lir_in_if.sink     i_in,
    lir_out_if.source  o_out,
    lir_cfg_if.sink    i_cfg
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_MUL_L = 2'd1;
    localparam logic [1:0] S_MUL_R = 2'd2;
    localparam logic [1:0] S_EMIT  = 2'd3;

    logic [1:0]       r_state, n_state;
    lir_pkg::t_ratio  r_ratio, n_ratio;
    logic             r_mono, n_mono;
    lir_pkg::t_sample r_prev_l, n_prev_l;
    lir_pkg::t_sample r_prev_r, n_prev_r;
    lir_pkg::t_sample r_cur_l, n_cur_l;
    lir_pkg::t_sample r_cur_r, n_cur_r;
    logic             r_have, n_have;
    lir_pkg::t_phase  r_phase, n_phase;
    lir_pkg::t_work   r_ph, n_ph;
    lir_pkg::t_cnt    r_cnt, n_cnt;
    lir_pkg::t_sample r_res_l, n_res_l;
    logic             r_out_valid, n_out_valid;
    lir_pkg::t_sample r_out_l, n_out_l;
    lir_pkg::t_sample r_out_r, n_out_r;
    logic             r_out_last, n_out_last;

    logic             w_sel_r;
    lir_pkg::t_sample w_a;
    lir_pkg::t_sample w_b;
    lir_pkg::t_sample w_q;
    lir_pkg::t_work   w_ph_next;
    logic             w_last;
    logic             w_out_free;
    logic             w_in_xfer;

    assign w_sel_r = (r_state != S_MUL_L);
    assign w_a     = w_sel_r ? r_prev_r : r_prev_l;
    assign w_b     = w_sel_r ? r_cur_r : r_cur_l;

    lir_interp u_interp (
        .i_clk  (i_clk),
        .i_a    (w_a),
        .i_b    (w_b),
        .i_frac (r_ph[lir_pkg::FRAC_BITS-1:0]),
        .o_q    (w_q)
    );

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign w_in_xfer   = i_in.valid && i_in.ready;
    assign w_out_free  = !r_out_valid || o_out.ready;
    assign w_ph_next   = r_ph + lir_pkg::t_work'(r_ratio);
    assign w_last      = (w_ph_next >= lir_pkg::ONE_FRAME)
                      || (r_cnt == lir_pkg::t_cnt'(lir_pkg::MAX_UPSAMPLE - 1));

    assign o_out.valid       = r_out_valid;
    assign o_out.out_left    = r_out_l;
    assign o_out.out_right   = r_out_r;
    assign o_out.last_of_run = r_out_last;

    always_comb begin
        n_state     = r_state;
        n_ratio     = r_ratio;
        n_mono      = r_mono;
        n_prev_l    = r_prev_l;
        n_prev_r    = r_prev_r;
        n_cur_l     = r_cur_l;
        n_cur_r     = r_cur_r;
        n_have      = r_have;
        n_phase     = r_phase;
        n_ph        = r_ph;
        n_cnt       = r_cnt;
        n_res_l     = r_res_l;
        n_out_valid = r_out_valid;
        n_out_l     = r_out_l;
        n_out_r     = r_out_r;
        n_out_last  = r_out_last;

        if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.wr_index)
                lir_pkg::CFG_RATIO: n_ratio = i_cfg.wr_data[lir_pkg::RATIO_W-1:0];
                lir_pkg::CFG_MONO:  n_mono  = i_cfg.wr_data[0];
                default:            n_mono  = r_mono;
            endcase
        end

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    n_cur_l = i_in.left_sample;
                    n_cur_r = i_in.right_sample;
                    if (i_in.restart || !r_have) begin
                        n_prev_l = i_in.left_sample;
                        n_prev_r = i_in.right_sample;
                        n_have   = 1'b1;
                        if (i_in.restart) begin
                            n_phase = '0;
                        end
                    end else if (lir_pkg::t_work'(r_phase) >= lir_pkg::ONE_FRAME) begin
                        n_phase  = lir_pkg::phase_wrap(lir_pkg::t_work'(r_phase));
                        n_prev_l = i_in.left_sample;
                        n_prev_r = i_in.right_sample;
                    end else begin
                        n_ph    = lir_pkg::t_work'(r_phase);
                        n_cnt   = '0;
                        n_state = S_MUL_L;
                    end
                end
            end
            S_MUL_L: begin
                n_state = S_MUL_R;
            end
            S_MUL_R: begin
                n_res_l = w_q;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_l     = r_res_l;
                    n_out_r     = r_mono ? r_res_l : w_q;
                    n_out_last  = w_last;
                    n_cnt       = r_cnt + 1'b1;
                    if (w_last) begin
                        n_phase  = lir_pkg::phase_wrap(w_ph_next);
                        n_prev_l = r_cur_l;
                        n_prev_r = r_cur_r;
                        n_state  = S_IDLE;
                    end else begin
                        n_ph    = w_ph_next;
                        n_state = S_MUL_L;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ratio     <= lir_pkg::RATIO_RESET;
            r_mono      <= 1'b0;
            r_have      <= 1'b0;
            r_phase     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ratio     <= n_ratio;
            r_mono      <= n_mono;
            r_have      <= n_have;
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prev_l   <= n_prev_l;
        r_prev_r   <= n_prev_r;
        r_cur_l    <= n_cur_l;
        r_cur_r    <= n_cur_r;
        r_ph       <= n_ph;
        r_cnt      <= n_cnt;
        r_res_l    <= n_res_l;
        r_out_l    <= n_out_l;
        r_out_r    <= n_out_r;
        r_out_last <= n_out_last;
    end

endmodule
